// ----- rtl/core/kuw_pkg.sv -----
// shared types and constants of the kuwahara filter
package kuw_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int LINES = 15;
    localparam logic [3:0] RADIUS = 4'd7;
    localparam logic [3:0] WIN_LAST = 4'd14;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;

    localparam logic [0:0] REG_WIDTH = 1'b0;
    localparam logic [0:0] REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [11:0] row;
        logic [3:0]  line;
        logic [11:0] h0;
        logic [11:0] h1;
        logic [10:0] w0;
        logic [10:0] w1;
    } kuw_job_t;

    typedef struct packed {
        logic        en;
        logic [3:0]  line;
        logic [10:0] col;
    } kuw_wr_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_MEAN,
        ST_VAR,
        ST_SEL
    } kuw_state_t;

endpackage

// ----- rtl/core/kuw_front.sv -----
// front end: pixel position, line store write and job generation
module kuw_front
    import kuw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [10:0] wd,
    input  logic [12:0] ht,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pixel,
    output kuw_wr_t     wr,
    output logic [7:0]  wr_data,
    output logic        push,
    output kuw_job_t    job,
    input  logic        q_full,
    input  logic        done
);

    logic [11:0] row_reg, row_next;
    logic [10:0] col_reg, col_next;
    logic [3:0]  line_reg, line_next;
    logic [2:0]  pend_reg, pend_next;
    logic [11:0] last_row_reg;
    logic [10:0] last_col_reg;

    logic        restart;
    logic [11:0] r;
    logic [10:0] c;
    logic [3:0]  ln;
    logic [12:0] ht_m1;
    logic [10:0] wd_m1;
    logic        has_r, has_c, has_job, hazard, accept;
    logic [11:0] c1;
    logic [12:0] r1;

    always_comb
    begin
        restart = (col_reg >= wd) || ({1'b0, row_reg} >= ht);
        r = restart ? 12'd0 : row_reg;
        c = restart ? 11'd0 : col_reg;
        ln = restart ? 4'd0 : line_reg;
        ht_m1 = ht - 13'd1;
        wd_m1 = wd - 11'd1;

        job.row = r;
        job.line = ln;
        has_r = 1'b1;
        if ({1'b0, r} == ht_m1)
        begin
            job.h0 = (r >= 12'(RADIUS)) ? r - 12'(RADIUS) : 12'd0;
            job.h1 = r;
        end
        else if (r >= 12'(RADIUS))
        begin
            job.h0 = r - 12'(RADIUS);
            job.h1 = r - 12'(RADIUS);
        end
        else
        begin
            job.h0 = 12'd0;
            job.h1 = 12'd0;
            has_r = 1'b0;
        end
        has_c = 1'b1;
        if (c == wd_m1)
        begin
            job.w0 = (c >= 11'(RADIUS)) ? c - 11'(RADIUS) : 11'd0;
            job.w1 = c;
        end
        else if (c >= 11'(RADIUS))
        begin
            job.w0 = c - 11'(RADIUS);
            job.w1 = c - 11'(RADIUS);
        end
        else
        begin
            job.w0 = 11'd0;
            job.w1 = 11'd0;
            has_c = 1'b0;
        end
        has_job = has_r && has_c;

        // a pending job may still read the line about to be overwritten
        hazard = (pend_reg != 3'd0) && !((r == last_row_reg) && (c > last_col_reg));
        in_stall = hazard || (has_job && q_full);
        accept = in_valid && !in_stall;
        push = accept && has_job;

        wr.en = accept;
        wr.line = ln;
        wr.col = c;
        wr_data = pixel;

        c1 = {1'b0, c} + 12'd1;
        r1 = {1'b0, r} + 13'd1;
        row_next = row_reg;
        col_next = col_reg;
        line_next = line_reg;
        if (accept)
        begin
            if (c1 >= {1'b0, wd})
            begin
                col_next = 11'd0;
                if (r1 >= ht)
                begin
                    row_next = 12'd0;
                    line_next = 4'd0;
                end
                else
                begin
                    row_next = r1[11:0];
                    line_next = (ln == WIN_LAST) ? 4'd0 : ln + 4'd1;
                end
            end
            else
            begin
                col_next = c1[10:0];
                row_next = r;
                line_next = ln;
            end
        end

        pend_next = pend_reg + {2'b00, push} - {2'b00, done};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= 12'd0;
            col_reg <= 11'd0;
            line_reg <= 4'd0;
            pend_reg <= 3'd0;
            last_row_reg <= 12'd0;
            last_col_reg <= 11'd0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
            line_reg <= line_next;
            pend_reg <= pend_next;
            if (push)
            begin
                last_row_reg <= r;
                last_col_reg <= c;
            end
        end
    end

endmodule

// ----- rtl/core/kuw_queue.sv -----
// job queue between front and back
module kuw_queue
    import kuw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  kuw_job_t job_in,
    output logic     full,
    input  logic     pop,
    output kuw_job_t job_out,
    output logic     empty
);

    kuw_job_t entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wp_reg, rp_reg;
    logic [QPTR_W:0]   cnt_reg;

    assign full = (cnt_reg == (QPTR_W+1)'(QDEPTH));
    assign empty = (cnt_reg == '0);
    assign job_out = entry_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wp_reg] <= job_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
        end
    end

endmodule

// ----- rtl/core/kuw_back.sv -----
// back end: line store, window statistics and quadrant selection
module kuw_back
    import kuw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [10:0] wd,
    input  logic [12:0] ht,
    input  kuw_wr_t     wr,
    input  logic [7:0]  wr_data,
    input  logic        q_empty,
    input  kuw_job_t    q_job,
    output logic        pop,
    output logic        done,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] out_row,
    output logic [9:0]  out_col,
    output logic [7:0]  out_value,
    output logic        last
);

    localparam int DEPTH = LINES * MAX_WIDTH;
    localparam int AW = $clog2(DEPTH);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_q;
    logic [AW-1:0] wr_addr, rd_addr;

    kuw_state_t state_reg, state_next;
    kuw_job_t job_reg;
    logic [11:0] h_reg;
    logic [10:0] w_reg;
    logic [3:0]  iy_reg, ix_reg;
    logic        rdv_reg;
    logic [3:0]  mask_reg, mask;
    logic [13:0] sum_reg [4];
    logic [21:0] sq_reg [4];
    logic [7:0]  mean_reg [4];
    logic [15:0] sqd_reg [4];
    logic [15:0] var_reg [4];
    logic        out_valid_reg;
    logic [11:0] out_row_reg;
    logic [9:0]  out_col_reg;
    logic [7:0]  out_value_reg;
    logic        last_reg;

    logic start, issue, load_out, adv, is_last;
    logic signed [13:0] rv;
    logic signed [12:0] cv;
    logic [11:0] rr, d;
    logic [10:0] cc;
    logic [11:0] ht_m1;
    logic [10:0] wd_m1;
    logic [4:0]  ln5;
    logic [3:0]  ln;
    logic [1:0]  best;
    logic [15:0] best_var;

    // window address
    always_comb
    begin
        ht_m1 = 12'(ht - 13'd1);
        wd_m1 = wd - 11'd1;
        rv = $signed({2'b00, h_reg}) + $signed({10'd0, iy_reg}) - 14'sd7;
        if (rv[13])
        begin
            rr = 12'd0;
        end
        else if (rv[12:0] > {1'b0, ht_m1})
        begin
            rr = ht_m1;
        end
        else
        begin
            rr = rv[11:0];
        end
        d = job_reg.row - rr;
        ln5 = {1'b0, job_reg.line} - {1'b0, d[3:0]};
        ln = ln5[4] ? ln5[3:0] + 4'(LINES) : ln5[3:0];
        cv = $signed({2'b00, w_reg}) + $signed({9'd0, ix_reg}) - 13'sd7;
        if (cv[12])
        begin
            cc = 11'd0;
        end
        else if (cv[11:0] > {1'b0, wd_m1})
        begin
            cc = wd_m1;
        end
        else
        begin
            cc = cv[10:0];
        end
        rd_addr = AW'(ln) * AW'(MAX_WIDTH) + AW'(cc);
        wr_addr = AW'(wr.line) * AW'(MAX_WIDTH) + AW'(wr.col);
        mask[0] = (iy_reg <= RADIUS) && (ix_reg <= RADIUS);
        mask[1] = (iy_reg <= RADIUS) && (ix_reg >= RADIUS);
        mask[2] = (iy_reg >= RADIUS) && (ix_reg >= RADIUS);
        mask[3] = (iy_reg >= RADIUS) && (ix_reg <= RADIUS);
    end

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_q <= mem[rd_addr];
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        pop = 1'b0;
        start = 1'b0;
        issue = 1'b0;
        load_out = 1'b0;
        adv = 1'b0;
        done = 1'b0;
        is_last = (h_reg == job_reg.h1) && (w_reg == job_reg.w1);
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    start = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                issue = 1'b1;
                if ((iy_reg == WIN_LAST) && (ix_reg == WIN_LAST))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_MEAN;
            ST_MEAN:  state_next = ST_VAR;
            ST_VAR:   state_next = ST_SEL;
            ST_SEL:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out = 1'b1;
                    if (is_last)
                    begin
                        done = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        adv = 1'b1;
                        start = 1'b1;
                        state_next = ST_READ;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // least variance, earlier quadrant wins a tie
    always_comb
    begin
        best = 2'd0;
        best_var = var_reg[0];
        for (int q = 1; q < 4; q++)
        begin
            if (var_reg[q] < best_var)
            begin
                best = 2'(q);
                best_var = var_reg[q];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rdv_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rdv_reg <= issue;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_job;
            h_reg <= q_job.h0;
            w_reg <= q_job.w0;
        end
        else if (adv)
        begin
            if (w_reg == job_reg.w1)
            begin
                w_reg <= job_reg.w0;
                h_reg <= h_reg + 12'd1;
            end
            else
            begin
                w_reg <= w_reg + 11'd1;
            end
        end
        if (start)
        begin
            iy_reg <= 4'd0;
            ix_reg <= 4'd0;
        end
        else if (issue)
        begin
            if (ix_reg == WIN_LAST)
            begin
                ix_reg <= 4'd0;
                iy_reg <= iy_reg + 4'd1;
            end
            else
            begin
                ix_reg <= ix_reg + 4'd1;
            end
        end
        mask_reg <= mask;
        for (int q = 0; q < 4; q++)
        begin
            if (start)
            begin
                sum_reg[q] <= 14'd0;
                sq_reg[q] <= 22'd0;
            end
            else if (rdv_reg && mask_reg[q])
            begin
                sum_reg[q] <= sum_reg[q] + 14'(rd_q);
                sq_reg[q] <= sq_reg[q] + 22'({8'd0, rd_q} * {8'd0, rd_q});
            end
            mean_reg[q] <= sum_reg[q][13:6];
            sqd_reg[q] <= sq_reg[q][21:6];
            var_reg[q] <= sqd_reg[q] - {8'd0, mean_reg[q]} * {8'd0, mean_reg[q]};
        end
        if (load_out)
        begin
            out_row_reg <= h_reg;
            out_col_reg <= w_reg[9:0];
            out_value_reg <= mean_reg[best];
            last_reg <= is_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row = out_row_reg;
    assign out_col = out_col_reg;
    assign out_value = out_value_reg;
    assign last = last_reg;

endmodule

// ----- rtl/core/kuwahara_filter_r7_top.sv -----
// top level of the radius 7 kuwahara filter
// Grey pixels enter in raster order at up to one per clock. For each filtered
// pixel the back end reads its 15x15 window from the single read port of the
// 15-line store one pixel per clock, followed by mean, variance and selection
// steps. A four-entry job queue decouples intake from filtering; intake pauses
// when the queue is full or when the next pixel would overwrite a line that a
// queued job still reads, so the sustained rate is set by the store's read port.
// Results carry their row and column and last marks the final result of an
// input pixel. Configuration must be written only while the block is idle; the
// block itself does not enforce this.
module kuwahara_filter_r7_top
    import kuw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [11:0] out_row,
    output logic [9:0]  out_col,
    output logic [7:0]  out_value,
    output logic        last
);

    logic [10:0] image_width_reg;
    logic [12:0] image_height_reg;
    logic [10:0] wd;
    logic [12:0] ht;
    kuw_wr_t     wr;
    logic [7:0]  wr_data;
    logic        push, pop, q_full, q_empty, done;
    kuw_job_t    job_in, job_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= 11'd640;
            image_height_reg <= 13'd480;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_WIDTH:  image_width_reg <= cfg_data[10:0];
                REG_HEIGHT: image_height_reg <= cfg_data;
                default:    image_width_reg <= image_width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (image_width_reg == 11'd0)
        begin
            wd = 11'd1;
        end
        else if (13'(image_width_reg) > 13'(MAX_WIDTH))
        begin
            wd = 11'(MAX_WIDTH);
        end
        else
        begin
            wd = image_width_reg;
        end
        if (image_height_reg == 13'd0)
        begin
            ht = 13'd1;
        end
        else if (image_height_reg > 13'd4096)
        begin
            ht = 13'd4096;
        end
        else
        begin
            ht = image_height_reg;
        end
    end

    kuw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wd       (wd),
        .ht       (ht),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .pixel    (pixel),
        .wr       (wr),
        .wr_data  (wr_data),
        .push     (push),
        .job      (job_in),
        .q_full   (q_full),
        .done     (done)
    );

    kuw_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .job_in  (job_in),
        .full    (q_full),
        .pop     (pop),
        .job_out (job_out),
        .empty   (q_empty)
    );

    kuw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .wd        (wd),
        .ht        (ht),
        .wr        (wr),
        .wr_data   (wr_data),
        .q_empty   (q_empty),
        .q_job     (job_out),
        .pop       (pop),
        .done      (done),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .last      (last)
    );

endmodule

// ----- tb/kuwahara_filter_r7_top_tb.sv -----
// testbench of the radius 7 kuwahara filter: scoreboard prediction, random stalls and gaps
`timescale 1ns / 1ps

module kuwahara_filter_r7_top_tb
    import kuw_pkg::*;
();

    typedef struct {
        logic [11:0] row;
        logic [9:0]  col;
        logic [7:0]  value;
        logic        last;
    } filtered_px_t;

    class kuw_scoreboard;
        logic [7:0]   line_buf [15*1024];
        int unsigned  next_row;
        int unsigned  next_col;
        logic [10:0]  width_reg;
        logic [12:0]  height_reg;
        filtered_px_t expected_px [$];
        int           errors;

        function new();
            next_row = 0;
            next_col = 0;
            width_reg = 11'd640;
            height_reg = 13'd480;
            errors = 0;
            foreach (line_buf[i])
                line_buf[i] = 8'd0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [12:0] data);
            if (idx == REG_WIDTH)
                width_reg = data[10:0];
            else
                height_reg = data;
        endfunction

        function int eff_width();
            if (width_reg == 0)
                return 1;
            if (width_reg > 1024)
                return 1024;
            return int'(width_reg);
        endfunction

        function int eff_height();
            if (height_reg == 0)
                return 1;
            if (height_reg > 4096)
                return 4096;
            return int'(height_reg);
        endfunction

        function int pick(int r, int c, int wd, int ht);
            int rr;
            int cc;
            rr = r < 0 ? 0 : (r > ht - 1 ? ht - 1 : r);
            cc = c < 0 ? 0 : (c > wd - 1 ? wd - 1 : c);
            return int'(line_buf[(rr % 15) * 1024 + cc]);
        endfunction

        function logic [7:0] smooth(int h, int w, int wd, int ht);
            int unsigned sum;
            int unsigned sq;
            int unsigned mean;
            int unsigned var_q;
            int unsigned best_var;
            int unsigned best_mean;
            int r0;
            int c0;
            int p;
            best_var = 0;
            best_mean = 0;
            for (int q = 0; q < 4; q++)
            begin
                r0 = (q < 2) ? -7 : 0;
                c0 = (q == 0 || q == 3) ? -7 : 0;
                sum = 0;
                sq = 0;
                for (int i = 0; i < 8; i++)
                    for (int j = 0; j < 8; j++)
                    begin
                        p = pick(h + r0 + i, w + c0 + j, wd, ht);
                        sum += unsigned'(p);
                        sq += unsigned'(p * p);
                    end
                mean = sum / 64;
                var_q = sq / 64 - mean * mean;
                if (q == 0 || var_q < best_var)
                begin
                    best_var = var_q;
                    best_mean = mean;
                end
            end
            return best_mean[7:0];
        endfunction

        function void note_pixel(logic [7:0] px);
            int wd;
            int ht;
            int r;
            int c;
            int h0;
            int h1;
            int w0;
            int w1;
            int n;
            filtered_px_t e;
            wd = eff_width();
            ht = eff_height();
            if (next_col >= unsigned'(wd) || next_row >= unsigned'(ht))
            begin
                next_row = 0;
                next_col = 0;
            end
            r = int'(next_row);
            c = int'(next_col);
            line_buf[(r % 15) * 1024 + c] = px;
            if (r == ht - 1)
            begin
                h0 = r >= 7 ? r - 7 : 0;
                h1 = r;
            end
            else if (r >= 7)
            begin
                h0 = r - 7;
                h1 = h0;
            end
            else
            begin
                h0 = 1;
                h1 = 0;
            end
            if (c == wd - 1)
            begin
                w0 = c >= 7 ? c - 7 : 0;
                w1 = c;
            end
            else if (c >= 7)
            begin
                w0 = c - 7;
                w1 = w0;
            end
            else
            begin
                w0 = 1;
                w1 = 0;
            end
            n = 0;
            for (int h = h0; h <= h1; h++)
                for (int w = w0; w <= w1; w++)
                begin
                    e.row = 12'(h);
                    e.col = 10'(w);
                    e.value = smooth(h, w, wd, ht);
                    e.last = 1'b0;
                    expected_px.push_back(e);
                    n++;
                end
            if (n > 0)
                expected_px[expected_px.size() - 1].last = 1'b1;
            next_col++;
            if (next_col >= unsigned'(wd))
            begin
                next_col = 0;
                next_row++;
                if (next_row >= unsigned'(ht))
                    next_row = 0;
            end
        endfunction

        function void check_result(logic [11:0] row, logic [9:0] col, logic [7:0] value,
                                   logic lst);
            filtered_px_t e;
            if (expected_px.size() == 0)
            begin
                $display("%0t: unexpected result row %0d col %0d value %0d", $time, row, col,
                         value);
                errors++;
                return;
            end
            e = expected_px.pop_front();
            if (row !== e.row)
            begin
                $display("%0t: out_row expected %0d actual %0d", $time, e.row, row);
                errors++;
            end
            if (col !== e.col)
            begin
                $display("%0t: out_col expected %0d actual %0d", $time, e.col, col);
                errors++;
            end
            if (value !== e.value)
            begin
                $display("%0t: out_value expected %0d actual %0d", $time, e.value, value);
                errors++;
            end
            if (lst !== e.last)
            begin
                $display("%0t: last expected %0d actual %0d", $time, e.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [0:0]  cfg_index;
    logic [12:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  pixel;
    logic        out_valid;
    logic        out_stall;
    logic [11:0] out_row;
    logic [9:0]  out_col;
    logic [7:0]  out_value;
    logic        last;

    kuw_scoreboard sb = new();
    int send_gap_pct;
    int recv_stall_pct;
    int hold_cycles;
    int pixels_sent;

    kuwahara_filter_r7_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .pixel     (pixel),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .out_value (out_value),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #6_000_000;
        $display("Mismatches found");
        $finish;
    end

    // receiver side
    initial
    begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles != hold_seen)
            begin
                hold_left = hold_cycles;
                hold_seen = hold_cycles;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_row, out_col, out_value, last);

    task automatic write_cfg(logic [0:0] idx, logic [12:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
    endtask

    task automatic send_pixel(logic [7:0] px);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel <= px;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_pixel(px);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (sb.expected_px.size() != 0)
            @(posedge clk);
        repeat (1000) @(posedge clk);
    endtask

    task automatic set_idling(int phase);
        case (phase % 4)
            0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_gap_pct = 47; recv_stall_pct = 0;  end
            2: begin send_gap_pct = 0;  recv_stall_pct = 47; end
            default: begin send_gap_pct = 8; recv_stall_pct = 8; end
        endcase
    endtask

    task automatic send_frame(int w, int h, int style);
        logic [7:0] base;
        logic [7:0] px;
        base = 8'($urandom_range(255));
        for (int i = 0; i < w * h; i++)
        begin
            case (style)
                0: px = base;
                1: px = $urandom_range(1) ? 8'd255 : 8'd0;
                2: px = base ^ 8'($urandom_range(3));
                default: px = 8'($urandom_range(255));
            endcase
            send_pixel(px);
        end
    endtask

    initial
    begin
        int w;
        int h;
        int phase;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        pixel = '0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        pixels_sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 3x3 frame, extremes and a uniform frame
        write_cfg(REG_WIDTH, 13'd3);
        write_cfg(REG_HEIGHT, 13'd3);
        for (int i = 0; i < 9; i++)
            send_pixel(i[0] ? 8'd255 : 8'd0);
        send_frame(3, 3, 0);
        drain();
        // zero sizes act as 1x1
        write_cfg(REG_WIDTH, 13'd0);
        write_cfg(REG_HEIGHT, 13'd0);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd170);
        drain();
        // tallest frame, one column
        write_cfg(REG_WIDTH, 13'd1);
        write_cfg(REG_HEIGHT, 13'd8191);
        send_frame(1, 24, 3);
        drain();
        // widest frame, one row; position falls outside so the frame restarts
        write_cfg(REG_WIDTH, 13'd2047);
        write_cfg(REG_HEIGHT, 13'd1);
        send_frame(24, 1, 3);
        drain();

        // width below 24 restarts the frame again, as the position stands at column 24
        phase = 0;
        while (pixels_sent < 460 || phase <= 5)
        begin
            w = $urandom_range(1, 16);
            h = $urandom_range(1, (120 / w) > 20 ? 20 : 120 / w);
            if (phase == 5)
            begin
                w = 10;
                h = 10;
            end
            write_cfg(REG_WIDTH, 13'(w));
            write_cfg(REG_HEIGHT, 13'(h));
            set_idling(phase);
            if (phase == 5)
            begin
                send_gap_pct = 0;
                hold_cycles = 3000;
            end
            send_frame(w, h, $urandom_range(3) == 0 ? $urandom_range(2) : 3);
            drain();
            phase++;
        end

        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
